@@ hdl/e2q_pkg.sv @@
`default_nettype none
package e2q_pkg;

  localparam int AngleBits    = 16;
  localparam int PartBits     = 16;
  localparam int CordicStages = 16;
  localparam int CordicW      = 34;
  localparam int ProdW        = 66;

  localparam logic signed [CordicW-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [CordicW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [CordicW-1:0] KQ30      = 34'sd652032874;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef struct packed {
    logic signed [AngleBits-1:0] angle_x;
    logic signed [AngleBits-1:0] angle_y;
    logic signed [AngleBits-1:0] angle_z;
  } angles_t;

  typedef struct packed {
    logic signed [PartBits-1:0] quat_w;
    logic signed [PartBits-1:0] quat_x;
    logic signed [PartBits-1:0] quat_y;
    logic signed [PartBits-1:0] quat_z;
  } quat_t;

  function automatic logic signed [CordicW-1:0] atan_q30(input logic [4:0] n);
    logic signed [CordicW-1:0] r;
    begin
      case (n)
        5'd0: r = 34'sh3243F6A8;
        5'd1: r = 34'sh1DAC6705;
        5'd2: r = 34'sh0FADBAFC;
        5'd3: r = 34'sh07F56EA6;
        5'd4: r = 34'sh03FEAB76;
        5'd5: r = 34'sh01FFD55B;
        5'd6: r = 34'sh00FFFAAA;
        5'd7: r = 34'sh007FFF55;
        5'd8: r = 34'sh003FFFEA;
        5'd9: r = 34'sh001FFFFD;
        5'd10: r = 34'sh000FFFFF;
        5'd11: r = 34'sh0007FFFF;
        5'd12: r = 34'sh0003FFFF;
        5'd13: r = 34'sh0001FFFF;
        5'd14: r = 34'sh0000FFFF;
        5'd15: r = 34'sh00007FFF;
        5'd16: r = 34'sh00003FFF;
        5'd17: r = 34'sh00001FFF;
        5'd18: r = 34'sh00000FFF;
        5'd19: r = 34'sh000007FF;
        5'd20: r = 34'sh000003FF;
        5'd21: r = 34'sh000001FF;
        5'd22: r = 34'sh000000FF;
        5'd23: r = 34'sh0000007F;
        5'd24: r = 34'sh0000003F;
        5'd25: r = 34'sh0000001F;
        5'd26: r = 34'sh0000000F;
        5'd27: r = 34'sh00000008;
        5'd28: r = 34'sh00000004;
        5'd29: r = 34'sh00000002;
        5'd30: r = 34'sh00000001;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

@@ hdl/e2q_cordic.sv @@
`default_nettype none
module e2q_cordic import e2q_pkg::*; (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  input  wire  signed [AngleBits:0]  angle_i,
  output logic                       valid_o,
  output logic signed [CordicW-1:0]  sin_o,
  output logic signed [CordicW-1:0]  cos_o
);

  localparam int Sh = 29 - (AngleBits - 4);

  logic signed [CordicW-1:0] h, hr;
  logic                      fl;

  logic                      v_q   [CordicStages+1];
  logic signed [CordicW-1:0] x_q   [CordicStages+1];
  logic signed [CordicW-1:0] y_q   [CordicStages+1];
  logic signed [CordicW-1:0] z_q   [CordicStages+1];
  logic                      fl_q  [CordicStages+1];

  always_comb begin
    h  = CordicW'(angle_i) <<< Sh;
    hr = h;
    fl = 1'b0;
    if (h > HalfPiQ30) begin
      hr = h - PiQ30;
      fl = 1'b1;
    end else if (h < -HalfPiQ30) begin
      hr = h + PiQ30;
      fl = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= KQ30;
    y_q[0]  <= '0;
    z_q[0]  <= hr;
    fl_q[0] <= fl;
  end

  for (genvar n = 0; n < CordicStages; n++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[n+1] <= 1'b0;
      end else begin
        v_q[n+1] <= v_q[n];
      end
    end
    always_ff @(posedge clk_i) begin
      fl_q[n+1] <= fl_q[n];
      if (!z_q[n][CordicW-1]) begin
        x_q[n+1] <= x_q[n] - (y_q[n] >>> n);
        y_q[n+1] <= y_q[n] + (x_q[n] >>> n);
        z_q[n+1] <= z_q[n] - atan_q30(5'(n));
      end else begin
        x_q[n+1] <= x_q[n] + (y_q[n] >>> n);
        y_q[n+1] <= y_q[n] - (x_q[n] >>> n);
        z_q[n+1] <= z_q[n] + atan_q30(5'(n));
      end
    end
  end

  assign valid_o = v_q[CordicStages];
  assign sin_o   = fl_q[CordicStages] ? -y_q[CordicStages] : y_q[CordicStages];
  assign cos_o   = fl_q[CordicStages] ? -x_q[CordicStages] : x_q[CordicStages];

endmodule
`default_nettype wire

@@ hdl/euler_to_quaternion_core.sv @@
// Channel  | Signals                              | Transfer
// input    | start_i, busy_o, angles_i            | start_i high while busy_o low
// result   | done_o, quat_o                       | one cycle with done_o high
// config   | cfg_valid_i, cfg_ready_o, cfg_data_i | valid and ready both high
// Transactions complete in order; the core accepts one per cycle.
// Each passes through the CORDIC stage chain, four arithmetic stages (A to D) and the output register.
// busy_o is always low, so a transaction can enter in every cycle.
// Reset clears all valid bits and the order code; the receiver cannot stall.
`default_nettype none
module euler_to_quaternion_core import e2q_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          start_i,
  output logic         busy_o,
  input  wire angles_t angles_i,
  output logic         done_o,
  output quat_t        quat_o,
  input  wire          cfg_valid_i,
  output logic         cfg_ready_o,
  input  wire  [4:0]   cfg_data_i
);

  logic [4:0] order_q;
  logic       acc;
  logic       rot, rep, odd;
  logic [1:0] ai, aj;
  logic signed [AngleBits:0] t1, t2, t3;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= '0;
    end else if (cfg_valid_i) begin
      order_q <= cfg_data_i;
    end
  end

  always_comb begin
    rot = order_q[0];
    rep = order_q[1];
    odd = order_q[2];
    case (order_q[4:3])
      AxisY: ai = AxisY;
      AxisZ: ai = AxisZ;
      default: ai = AxisX;
    endcase
    case (ai)
      AxisX: aj = odd ? AxisZ : AxisY;
      AxisY: aj = odd ? AxisX : AxisZ;
      default: aj = odd ? AxisY : AxisX;
    endcase
    t1 = rot ? (AngleBits+1)'(angles_i.angle_z) : (AngleBits+1)'(angles_i.angle_x);
    t3 = rot ? (AngleBits+1)'(angles_i.angle_x) : (AngleBits+1)'(angles_i.angle_z);
    t2 = odd ? -(AngleBits+1)'(angles_i.angle_y) : (AngleBits+1)'(angles_i.angle_y);
  end

  localparam int CtlDepth = CordicStages + 1;
  logic [5:0] ctl_q [CtlDepth+1];

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= {rep, odd, ai, aj};
  end
  for (genvar i = 0; i < CtlDepth; i++) begin : g_ctl
    always_ff @(posedge clk_i) ctl_q[i+1] <= ctl_q[i];
  end

  logic v1, v2, v3;
  logic signed [CordicW-1:0] si, ci, sj, cj, sh, ch;

  e2q_cordic u_c1 (.clk_i, .rst_ni, .valid_i(acc), .angle_i(t1),
                   .valid_o(v1), .sin_o(si), .cos_o(ci));
  e2q_cordic u_c2 (.clk_i, .rst_ni, .valid_i(acc), .angle_i(t2),
                   .valid_o(v2), .sin_o(sj), .cos_o(cj));
  e2q_cordic u_c3 (.clk_i, .rst_ni, .valid_i(acc), .angle_i(t3),
                   .valid_o(v3), .sin_o(sh), .cos_o(ch));

  // Stage A: pair products.
  logic                      va_q;
  logic signed [ProdW-1:0]   pcc_q, pcs_q, psc_q, pss_q;
  logic signed [CordicW-1:0] sja_q, cja_q;
  // Stage B: rounded pairs, combined into sums and differences in repeated-axis mode.
  logic                      vb_q;
  logic signed [CordicW+1:0] cc_q, cs_q, sc_q, ss_q;
  logic signed [CordicW-1:0] sjb_q, cjb_q;
  // Stage C: products with cj and sj.
  logic                      vc_q;
  logic signed [ProdW+2:0]   m_q [8];
  // Stage D: final Q60 sums, or selected Q60 products in repeated-axis mode.
  logic                      vd_q;
  logic signed [ProdW+3:0]   r_q [4];
  logic [5:0]                ctl_a, ctl_b, ctl_c, ctl_d;

  assign ctl_a = ctl_q[CtlDepth];

  logic signed [CordicW+1:0] cc_r, cs_r, sc_r, ss_r;
  always_comb begin
    cc_r = (CordicW+2)'((pcc_q + (ProdW'(1) <<< 29)) >>> 30);
    cs_r = (CordicW+2)'((pcs_q + (ProdW'(1) <<< 29)) >>> 30);
    sc_r = (CordicW+2)'((psc_q + (ProdW'(1) <<< 29)) >>> 30);
    ss_r = (CordicW+2)'((pss_q + (ProdW'(1) <<< 29)) >>> 30);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0; vc_q <= 1'b0; vd_q <= 1'b0; done_o <= 1'b0;
    end else begin
      va_q <= v1 & v2 & v3;
      vb_q <= va_q; vc_q <= vb_q; vd_q <= vc_q; done_o <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pcc_q <= ProdW'(ci) * ProdW'(ch);
    pcs_q <= ProdW'(ci) * ProdW'(sh);
    psc_q <= ProdW'(si) * ProdW'(ch);
    pss_q <= ProdW'(si) * ProdW'(sh);
    sja_q <= sj; cja_q <= cj; ctl_b <= ctl_a;
    if (ctl_a[5]) begin
      cc_q <= cc_r - ss_r;
      cs_q <= cs_r + sc_r;
      sc_q <= cc_r + ss_r;
      ss_q <= cs_r - sc_r;
    end else begin
      cc_q <= cc_r; cs_q <= cs_r; sc_q <= sc_r; ss_q <= ss_r;
    end
    sjb_q <= sja_q; cjb_q <= cja_q; ctl_c <= ctl_b;
    m_q[0] <= (ProdW+3)'(cjb_q) * (ProdW+3)'(cc_q);
    m_q[1] <= (ProdW+3)'(sjb_q) * (ProdW+3)'(ss_q);
    m_q[2] <= (ProdW+3)'(cjb_q) * (ProdW+3)'(sc_q);
    m_q[3] <= (ProdW+3)'(sjb_q) * (ProdW+3)'(cs_q);
    m_q[4] <= (ProdW+3)'(cjb_q) * (ProdW+3)'(ss_q);
    m_q[5] <= (ProdW+3)'(sjb_q) * (ProdW+3)'(cc_q);
    m_q[6] <= (ProdW+3)'(cjb_q) * (ProdW+3)'(cs_q);
    m_q[7] <= (ProdW+3)'(sjb_q) * (ProdW+3)'(sc_q);
    ctl_d <= ctl_c;
    if (ctl_c[5]) begin
      r_q[0] <= (ProdW+4)'(m_q[0]);
      r_q[1] <= (ProdW+4)'(m_q[6]);
      r_q[2] <= (ProdW+4)'(m_q[7]);
      r_q[3] <= (ProdW+4)'(m_q[1]);
    end else begin
      r_q[0] <= (ProdW+4)'(m_q[0]) + (ProdW+4)'(m_q[1]);
      r_q[1] <= (ProdW+4)'(m_q[2]) - (ProdW+4)'(m_q[3]);
      r_q[2] <= (ProdW+4)'(m_q[4]) + (ProdW+4)'(m_q[5]);
      r_q[3] <= (ProdW+4)'(m_q[6]) - (ProdW+4)'(m_q[7]);
    end
  end

  localparam int Rs = 62 - PartBits;
  localparam logic signed [ProdW+3:0] Lim = (ProdW+4)'(1) <<< (PartBits - 2);

  function automatic logic signed [PartBits-1:0] to_part(
      input logic signed [ProdW+3:0] v, input logic neg);
    logic signed [ProdW+3:0] r;
    begin
      r = (v + ((ProdW+4)'(1) <<< (Rs - 1))) >>> Rs;
      if (r > Lim) r = Lim;
      if (r < -Lim) r = -Lim;
      if (neg) r = -r;
      return PartBits'(r);
    end
  endfunction

  logic signed [ProdW+3:0] px, py, pz;
  logic [1:0] dai, daj, dak;
  logic       dodd;

  always_comb begin
    dodd = ctl_d[4];
    dai  = ctl_d[3:2];
    daj  = ctl_d[1:0];
    dak  = 2'd3 - dai - daj;
    px = (dai == AxisX) ? r_q[1] : (daj == AxisX) ? r_q[2] : r_q[3];
    py = (dai == AxisY) ? r_q[1] : (daj == AxisY) ? r_q[2] : r_q[3];
    pz = (dai == AxisZ) ? r_q[1] : (daj == AxisZ) ? r_q[2] : r_q[3];
    if (dak == 2'd3) begin
      px = r_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    quat_o.quat_w <= to_part(r_q[0], 1'b0);
    quat_o.quat_x <= to_part(px, dodd && daj == AxisX);
    quat_o.quat_y <= to_part(py, dodd && daj == AxisY);
    quat_o.quat_z <= to_part(pz, dodd && daj == AxisZ);
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_euler_to_quaternion_core.sv @@
`timescale 1ns / 1ps
module tb_euler_to_quaternion_core;
  import e2q_pkg::*;

  localparam int PipeCycles = CordicStages + 6;
  localparam logic [4:0] OrderMask = 5'h1f;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  angles_t angles = '0;
  logic done;
  quat_t quat;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;

  angles_t pending_angles[$];
  quat_t expected_quats[$];
  logic [4:0] order_model = '0;
  int error_count = 0;
  int idle_left = 0;
  bit idle_allowed = 1'b1;

  euler_to_quaternion_core u_top (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .angles_i(angles), .done_o(done), .quat_o(quat),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  task automatic half_sin_cos(input longint a, output longint s, output longint c);
    longint h, x, y, z, dx, dy;
    longint atan_tab[32];
    bit flip;
    begin
      atan_tab = '{32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
                   32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
                   32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
                   32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
                   32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
                   32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
                   32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
                   32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000};
      h = a * (longint'(1) <<< (29 - (AngleBits - 4)));
      flip = 1'b0;
      if (h > 64'sd1686629713) begin
        h -= 64'sd3373259426;
        flip = 1'b1;
      end else if (h < -64'sd1686629713) begin
        h += 64'sd3373259426;
        flip = 1'b1;
      end
      x = 64'sd652032874;
      y = 0;
      z = h;
      for (int n = 0; n < CordicStages; n++) begin
        dx = shr_floor(y, n);
        dy = shr_floor(x, n);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tab[n];
        end else begin
          x += dx; y -= dy; z += atan_tab[n];
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    end
  endtask

  function automatic logic [PartBits-1:0] to_component(longint v, bit neg);
    longint lim, r;
    begin
      lim = longint'(1) <<< (PartBits - 2);
      r = round_q(v, 62 - PartBits);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      if (neg) r = -r;
      return r[PartBits-1:0];
    end
  endfunction

  task automatic predict_quat(input angles_t a, output quat_t q);
    bit rotating, repeated, odd;
    int ai, aj, ak;
    longint t1, t2, t3, t, si, ci, sj, cj, sh, ch, cc, cs, sc, ss, w;
    longint part[3];
    int next_axis[4];
    begin
      next_axis = '{1, 2, 0, 1};
      rotating = order_model[0];
      repeated = order_model[1];
      odd = order_model[2];
      ai = (order_model[4:3] == 2'd3) ? int'(AxisX) : int'(order_model[4:3]);
      aj = next_axis[ai + (odd ? 1 : 0)];
      ak = next_axis[ai + (odd ? 0 : 1)];
      t1 = a.angle_x;
      t2 = a.angle_y;
      t3 = a.angle_z;
      if (rotating) begin
        t = t1; t1 = t3; t3 = t;
      end
      if (odd) t2 = -t2;
      half_sin_cos(t1, si, ci);
      half_sin_cos(t2, sj, cj);
      half_sin_cos(t3, sh, ch);
      cc = round_q(ci * ch, 30);
      cs = round_q(ci * sh, 30);
      sc = round_q(si * ch, 30);
      ss = round_q(si * sh, 30);
      if (repeated) begin
        part[ai] = cj * (cs + sc);
        part[aj] = sj * (cc + ss);
        part[ak] = sj * (cs - sc);
        w = cj * (cc - ss);
      end else begin
        part[ai] = cj * sc - sj * cs;
        part[aj] = cj * ss + sj * cc;
        part[ak] = cj * cs - sj * sc;
        w = cj * cc + sj * ss;
      end
      q.quat_w = to_component(w, 1'b0);
      q.quat_x = to_component(part[0], odd && aj == 0);
      q.quat_y = to_component(part[1], odd && aj == 1);
      q.quat_z = to_component(part[2], odd && aj == 2);
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_angles.size() > 0 && idle_allowed && $urandom_range(0, 9) == 0) begin
        idle_left <= int'($urandom_range(0, 4));
        start <= 1'b0;
      end else if (pending_angles.size() > 0) begin
        start <= 1'b1;
        angles <= pending_angles[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    quat_t q;
    if (rst_n) begin
      if (start && !busy && pending_angles.size() > 0) begin
        predict_quat(pending_angles[0], q);
        expected_quats.push_back(q);
        void'(pending_angles.pop_front());
      end
      if (done) begin
        if (expected_quats.size() == 0) begin
          $error("quat result with no transaction pending: %h", quat);
          error_count++;
        end else begin
          q = expected_quats.pop_front();
          if (quat.quat_w !== q.quat_w) begin
            $error("quat_w expected %0d actual %0d", q.quat_w, quat.quat_w);
            error_count++;
          end
          if (quat.quat_x !== q.quat_x) begin
            $error("quat_x expected %0d actual %0d", q.quat_x, quat.quat_x);
            error_count++;
          end
          if (quat.quat_y !== q.quat_y) begin
            $error("quat_y expected %0d actual %0d", q.quat_y, quat.quat_y);
            error_count++;
          end
          if (quat.quat_z !== q.quat_z) begin
            $error("quat_z expected %0d actual %0d", q.quat_z, quat.quat_z);
            error_count++;
          end
        end
      end
    end
  end

  task automatic drain;
    begin
      while (pending_angles.size() > 0 || expected_quats.size() > 0) @(posedge clk);
      repeat (PipeCycles + 4) @(posedge clk);
    end
  endtask

  task automatic write_order(input logic [4:0] code);
    begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data <= code;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      order_model = code & OrderMask;
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
  endtask

  function automatic logic signed [15:0] edge_angle();
    logic signed [15:0] picks[8];
    picks = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
              16'sh3244, -16'sh3244, 16'sh1922};
    return picks[$urandom_range(0, 7)];
  endfunction

  task automatic queue_angles(input logic signed [15:0] ax, input logic signed [15:0] ay,
                              input logic signed [15:0] az);
    angles_t a;
    begin
      a.angle_x = ax;
      a.angle_y = ay;
      a.angle_z = az;
      pending_angles.push_back(a);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_angles(16'sh8000, 16'sh8000, 16'sh8000);
    queue_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
    queue_angles(16'sh0000, 16'sh0000, 16'sh0000);
    queue_angles(16'sh8000, 16'sh7fff, 16'shffff);
    queue_angles(16'sh3244, 16'sh1922, -16'sh3244);
    drain();

    for (int c = 0; c < 32; c++) begin
      write_order(c[4:0]);
      queue_angles(16'sh8000, 16'sh8000, 16'sh7fff);
      queue_angles(16'sh1000, -16'sh2000, 16'sh0800);
      for (int i = 0; i < 32; i++)
        queue_angles(16'($urandom), 16'($urandom), 16'($urandom));
      for (int i = 0; i < 6; i++)
        queue_angles(edge_angle(), edge_angle(), edge_angle());
      drain();
    end

    write_order(5'd23);
    for (int i = 0; i < 300; i++) begin
      if (i == 200) begin
        idle_allowed = 1'b0;
      end
      queue_angles(16'($urandom), 16'($urandom), 16'($urandom));
    end
    drain();
    write_order(5'd0);
    for (int i = 0; i < 100; i++)
      queue_angles(16'($urandom), 16'($urandom), 16'($urandom));
    drain();

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/e2q_pkg.sv
hdl/e2q_cordic.sv
hdl/euler_to_quaternion_core.sv
tb/sv/tb_euler_to_quaternion_core.sv
